@@ rtl/core/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO core: the item and
// result layouts, the opcodes, the status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  // Storage geometry
  localparam int DEPTH        = 64;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int CHUNK_BYTES  = 8;
  localparam int CHUNK_IDX_W  = $clog2(CHUNK_BYTES);
  localparam int POS_W        = 16;
  localparam int DIV_CNT_W    = $clog2(POS_W);

  // Fixed reply bytes
  localparam logic [7:0] EMPTY_PEEK_BYTE = 8'd35;
  localparam logic [7:0] EMPTY_GET_BYTE  = 8'hFF;

  // Opcodes
  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_TRY_WRITE = 3'd1,
    OP_READ      = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_PEEK      = 3'd4,
    OP_GET       = 3'd5
  } brf_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOSPACE = 2'd1,
    STS_EMPTY   = 2'd2
  } brf_status_t;

  // Input item
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] chunk_bytes;
    logic [3:0]  chunk_len;
    logic [6:0]  count;
    logic [15:0] position;
  } brf_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] status;
    logic [6:0] done_count;
    logic       last;
  } brf_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PUSH,
    ST_POP,
    ST_POP_LAST,
    ST_DROP,
    ST_DIV,
    ST_GET_RD
  } brf_state_t;

  // Result source selection
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_REPLY,
    EMIT_POP,
    EMIT_GET
  } brf_emit_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      drop;
    logic      div_step;
    logic      get_rd;
    brf_emit_t emit;
    logic      last;
  } brf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       n_zero;
    logic       idx_zero;
    logic       idx_last;
    logic       empty;
    logic       div_last;
  } brf_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/brf_dp.sv @@
// ----------------------------------------------------------------------------
// brf_dp
// Datapath of the byte ring FIFO: ring storage, read slot and fill count,
// the latched item, a bit-serial remainder unit for get, and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_dp
  import brf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire brf_in_t         in_data,
  input  wire brf_cmd_t        cmd,
  output brf_sts_t             sts,
  output logic                 out_strobe,
  output brf_out_t             out_data
);

  // Ring storage
  logic [7:0] mem [DEPTH];

  // Control state
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              out_strobe_r;

  // Latched item and loop state
  logic [2:0]        op_r;
  logic [63:0]       data_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              empty_r;
  logic [CNT_W-1:0]  idx_r;
  logic [POS_W-1:0]  pos_r;
  logic [SLOT_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [7:0]        rd_data_r;
  brf_out_t          out_data_r;

  // Combinational helpers
  logic [3:0]        len_c;
  logic [CNT_W-1:0]  len_w;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  take;
  logic [CNT_W-1:0]  wr_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [CNT_W-1:0]  drop_sum;
  logic [SLOT_W-1:0] drop_slot;
  logic [SLOT_W-1:0] pop_slot;
  logic [CNT_W-1:0]  rem_t;
  logic [CNT_W-1:0]  rem_sub;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  cfg_cap;
  logic [SLOT_W-1:0] rd_addr;

  // Size the item against the current fill
  always_comb begin
    len_c = (in_data.chunk_len > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : in_data.chunk_len;
    len_w = CNT_W'(len_c);
    room  = cap_r - fill_r;
    take  = (in_data.count < fill_r) ? in_data.count : fill_r;
    n_nxt    = '0;
    st_nxt   = STS_OK;
    byte_nxt = '0;
    case (in_data.opcode)
      OP_WRITE: begin
        if (len_w > room) begin
          st_nxt = STS_NOSPACE;
        end else begin
          n_nxt = len_w;
        end
      end
      OP_TRY_WRITE: begin
        n_nxt  = (len_w < room) ? len_w : room;
        st_nxt = (room < len_w) ? STS_NOSPACE : STS_OK;
      end
      OP_READ, OP_REMOVE: begin
        n_nxt  = take;
        st_nxt = (fill_r == '0) ? STS_EMPTY : STS_OK;
      end
      OP_PEEK: begin
        if (fill_r == '0) begin
          st_nxt   = STS_EMPTY;
          byte_nxt = EMPTY_PEEK_BYTE;
        end else begin
          n_nxt = CNT_W'(1);
        end
      end
      OP_GET: begin
        if (fill_r == '0) begin
          st_nxt   = STS_EMPTY;
          byte_nxt = EMPTY_GET_BYTE;
        end
      end
      default: begin
      end
    endcase
  end

  // Slot arithmetic: every sum stays below twice the capacity
  always_comb begin
    wr_sum    = CNT_W'(read_slot_r) + fill_r;
    wr_slot   = (wr_sum >= cap_r) ? SLOT_W'(wr_sum - cap_r) : SLOT_W'(wr_sum);
    drop_sum  = CNT_W'(read_slot_r) + n_r;
    drop_slot = (drop_sum >= cap_r) ? SLOT_W'(drop_sum - cap_r) : SLOT_W'(drop_sum);
    pop_slot  = (CNT_W'(read_slot_r) + CNT_W'(1) == cap_r) ? '0 : read_slot_r + 1'b1;
    rem_t     = {rem_r, pos_r[POS_W-1]};
    rem_sub   = (rem_t >= cap_r) ? rem_t - cap_r : rem_t;
    idx_inc   = idx_r + 1'b1;
    rd_addr   = cmd.get_rd ? rem_r : read_slot_r;
  end

  // Clamp a capacity write into range
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(DEPTH)) begin
      cfg_cap = CNT_W'(DEPTH);
    end else begin
      cfg_cap = cfg_wdata;
    end
  end

  // Next ring pointers
  always_comb begin
    cap_nxt       = cap_r;
    read_slot_nxt = read_slot_r;
    fill_nxt      = fill_r;
    if (cfg_we) begin
      cap_nxt       = cfg_cap;
      read_slot_nxt = '0;
      fill_nxt      = '0;
    end else if (cmd.push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (cmd.pop) begin
      read_slot_nxt = pop_slot;
      fill_nxt      = fill_r - 1'b1;
    end else if (cmd.drop) begin
      read_slot_nxt = drop_slot;
      fill_nxt      = fill_r - n_r;
    end
  end

  // Hold ring pointers and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CNT_W'(DEPTH);
      read_slot_r <= '0;
      fill_r      <= '0;
    end else begin
      cap_r       <= cap_nxt;
      read_slot_r <= read_slot_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // Latch the item and advance the loop state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_data.opcode;
      data_r    <= in_data.chunk_bytes;
      pos_r     <= in_data.position;
      n_r       <= n_nxt;
      st_r      <= st_nxt;
      byte_r    <= byte_nxt;
      empty_r   <= (fill_r == '0);
      idx_r     <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.push || cmd.pop) begin
        idx_r <= idx_inc;
      end
      if (cmd.div_step) begin
        rem_r     <= SLOT_W'(rem_sub);
        pos_r     <= {pos_r[POS_W-2:0], 1'b0};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
    end
  end

  // Write and read the ring storage
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_slot] <= data_r[{idx_r[CHUNK_IDX_W-1:0], 3'b000} +: 8];
    end
    if (cmd.pop || cmd.get_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Drive the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_REPLY: out_data_r <= '{byte_out: byte_r, status: st_r, done_count: n_r, last: 1'b1};
      EMIT_POP:   out_data_r <= '{byte_out: rd_data_r, status: STS_OK, done_count: n_r,
                                  last: cmd.last};
      EMIT_GET:   out_data_r <= '{byte_out: rd_data_r, status: STS_OK, done_count: '0,
                                  last: 1'b1};
      default:    out_data_r <= out_data_r;
    endcase
  end

  // Status back to the controller
  always_comb begin
    sts.op       = op_r;
    sts.n_zero   = (n_r == '0);
    sts.idx_zero = (idx_r == '0);
    sts.idx_last = (idx_inc == n_r);
    sts.empty    = empty_r;
    sts.div_last = (div_cnt_r == DIV_CNT_W'(POS_W - 1));
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // The ring never holds more than its capacity
  a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap_r) else $error("fill count above capacity");

  // The oldest byte always sits inside the active ring
  a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(read_slot_r) < cap_r) else $error("read slot outside ring");

  // A push needs a free slot and a pop a stored byte
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> fill_r < cap_r) else $error("push into full ring");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> fill_r != '0) else $error("pop from empty ring");

  // The remainder stays below the capacity
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.get_rd |-> CNT_W'(rem_r) < cap_r) else $error("remainder out of range");

endmodule

`default_nettype wire

@@ rtl/core/brf_ctrl.sv @@
// ----------------------------------------------------------------------------
// brf_ctrl
// Controller of the byte ring FIFO: sequences one item at a time through
// dispatch, the byte loops, the remainder steps and the reply.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ctrl
  import brf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire brf_sts_t sts,
  output logic          busy,
  output brf_cmd_t      cmd
);

  brf_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.op) inside
          OP_WRITE, OP_TRY_WRITE: begin
            if (sts.n_zero) begin
              cmd.emit  = EMIT_REPLY;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_PUSH;
            end
          end
          OP_READ, OP_PEEK: begin
            if (sts.n_zero) begin
              cmd.emit  = EMIT_REPLY;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_POP;
            end
          end
          OP_REMOVE: begin
            state_nxt = ST_DROP;
          end
          OP_GET: begin
            if (sts.empty) begin
              cmd.emit  = EMIT_REPLY;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_DIV;
            end
          end
          default: begin
            cmd.emit  = EMIT_REPLY;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      // Store one byte a cycle, reply after the last
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_POP_LAST;
        end
      end
      // Pop one byte a cycle, emit the one read in the previous cycle
      ST_POP: begin
        cmd.pop = 1'b1;
        if (!sts.idx_zero) begin
          cmd.emit = EMIT_POP;
        end
        if (sts.idx_last) begin
          state_nxt = ST_POP_LAST;
        end
      end
      // Emit the final byte, the get byte, or the write reply after pushing
      ST_POP_LAST: begin
        cmd.last  = 1'b1;
        cmd.emit  = (sts.op == OP_READ || sts.op == OP_PEEK) ? EMIT_POP : EMIT_REPLY;
        state_nxt = ST_IDLE;
      end
      ST_DROP: begin
        cmd.drop  = 1'b1;
        cmd.emit  = EMIT_REPLY;
        state_nxt = ST_IDLE;
      end
      // One remainder bit a cycle
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_GET_RD;
        end
      end
      ST_GET_RD: begin
        cmd.get_rd = 1'b1;
        state_nxt  = ST_POP_LAST;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Get finishes through the same final state with its own source
    if (state_r == ST_POP_LAST && sts.op == OP_GET) begin
      cmd.emit = EMIT_GET;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/byte_ring_fifo_core.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_core
// Byte ring FIFO with run-time capacity, driven by one command at a time.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; results come out on
// out_data for one cycle each, marked by out_strobe, and must be taken as
// they come since the receiver cannot stall. A write or try-write that stores
// L bytes keeps busy high through dispatch, the pushes (one byte stored per
// cycle) and the reply; a read or peek popping N bytes through dispatch, the
// pops and the last emit, one result per cycle with last on the final one;
// and a remove through dispatch and the drop. An item that stores or pops
// nothing (a write without room or of no bytes, a read of nothing, a peek or
// get on an empty buffer, an unused opcode) replies straight from dispatch.
// A get on a non-empty buffer runs the bit-serial remainder unit, reducing
// the 16-bit position one bit per cycle, then the storage read. A capacity
// write clamps to 1..64 and empties the ring; issue it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_core
  import brf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire brf_in_t         in_data,
  output logic                 out_strobe,
  output brf_out_t             out_data,
  input  wire logic            cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  brf_cmd_t cmd;
  brf_sts_t sts;

  // Sequence the items
  brf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Store, fetch and report
  brf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for byte_ring_fifo_core. The bench drives command items
// with random gaps, predicts every result from its own model of the ring, and
// checks each strobed result field by field. It runs a directed opening and
// then random phases under several capacity settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import brf_pkg::*;
();

  localparam int GAP_MAX        = 11;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 26;

  // Opcodes the block must treat as no-ops
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // Ring model and store of expected results
  class ring_scoreboard;
    logic [7:0]  mem [DEPTH];
    bit          written [DEPTH];
    int unsigned head;
    int unsigned fill;
    int unsigned cap;
    brf_out_t    expq [$];
    int          errors;
    int          results_seen;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        mem[i]     = '0;
        written[i] = 1'b0;
      end
      head         = 0;
      fill         = 0;
      cap          = DEPTH;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Clamp to 1..DEPTH and empty the ring
    function void set_capacity(logic [6:0] v);
      if (v == 0) cap = 1;
      else if (v > DEPTH) cap = DEPTH;
      else cap = v;
      head = 0;
      fill = 0;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    // Steer a get away from slots that were never written
    function logic [15:0] fix_position(logic [15:0] p);
      int unsigned slot;
      int unsigned q;
      if (fill == 0) return p;
      slot = p % cap;
      if (written[slot]) return p;
      q = p - slot + head;
      if (q > 16'hFFFF) q -= cap;
      return q[15:0];
    endfunction

    function void push_byte(logic [7:0] b);
      int unsigned slot;
      slot          = (head + fill) % cap;
      mem[slot]     = b;
      written[slot] = 1'b1;
      fill++;
    endfunction

    function logic [7:0] pop_byte();
      logic [7:0] b;
      b    = mem[head % cap];
      head = (head + 1) % cap;
      fill--;
      return b;
    endfunction

    function void expect_result(logic [7:0] b, logic [1:0] st, logic [6:0] done, logic lst);
      brf_out_t r;
      r.byte_out   = b;
      r.status     = st;
      r.done_count = done;
      r.last       = lst;
      expq.insert(expq.size(), r);
    endfunction

    // Advance the model by one accepted item and queue its results
    function void note_item(brf_in_t it);
      int unsigned len;
      int unsigned cnt;
      int unsigned room;
      int unsigned n;
      logic [1:0]  st;
      len  = (it.chunk_len > CHUNK_BYTES) ? CHUNK_BYTES : it.chunk_len;
      cnt  = it.count;
      room = cap - fill;
      case (it.opcode)
        OP_WRITE: begin
          if (len > room) begin
            expect_result(8'd0, STS_NOSPACE, 7'd0, 1'b1);
          end else begin
            for (int i = 0; i < len; i++) push_byte(it.chunk_bytes[8*i +: 8]);
            expect_result(8'd0, STS_OK, 7'(len), 1'b1);
          end
        end
        OP_TRY_WRITE: begin
          n = (len < room) ? len : room;
          for (int i = 0; i < n; i++) push_byte(it.chunk_bytes[8*i +: 8]);
          expect_result(8'd0, (n < len) ? STS_NOSPACE : STS_OK, 7'(n), 1'b1);
        end
        OP_READ: begin
          n = (cnt < fill) ? cnt : fill;
          if (n > DEPTH) n = DEPTH;
          if (n == 0) begin
            expect_result(8'd0, (fill == 0) ? STS_EMPTY : STS_OK, 7'd0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              expect_result(pop_byte(), STS_OK, 7'(n), (i + 1 == n));
          end
        end
        OP_REMOVE: begin
          st   = (fill == 0) ? STS_EMPTY : STS_OK;
          n    = (cnt < fill) ? cnt : fill;
          head = (head + n) % cap;
          fill -= n;
          expect_result(8'd0, st, 7'(n), 1'b1);
        end
        OP_PEEK: begin
          if (fill == 0) expect_result(EMPTY_PEEK_BYTE, STS_EMPTY, 7'd0, 1'b1);
          else expect_result(pop_byte(), STS_OK, 7'd1, 1'b1);
        end
        OP_GET: begin
          if (fill == 0) expect_result(EMPTY_GET_BYTE, STS_EMPTY, 7'd0, 1'b1);
          else expect_result(mem[it.position % cap], STS_OK, 7'd0, 1'b1);
        end
        default: begin
          expect_result(8'd0, STS_OK, 7'd0, 1'b1);
        end
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Compare one strobed result with the oldest expectation
    task check_result(brf_out_t got);
      brf_out_t want;
      results_seen++;
      if (expq.size() == 0) begin
        report($sformatf("result %0d (%0h) arrived with nothing expected", results_seen, got));
        return;
      end
      want = expq.pop_front();
      if (got.byte_out !== want.byte_out)
        report($sformatf("result %0d byte_out %0h, wanted %0h",
                         results_seen, got.byte_out, want.byte_out));
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, wanted %0d",
                         results_seen, got.status, want.status));
      if (got.done_count !== want.done_count)
        report($sformatf("result %0d done_count %0d, wanted %0d",
                         results_seen, got.done_count, want.done_count));
      if (got.last !== want.last)
        report($sformatf("result %0d last %0b, wanted %0b",
                         results_seen, got.last, want.last));
    endtask
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  brf_in_t    in_data   = '0;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic       busy;
  logic       out_strobe;
  brf_out_t   out_data;

  ring_scoreboard sb = new();

  int  items_sent   = 0;
  int  cap_writes   = 0;
  int  stall_cycles = 0;
  bit  calm         = 1'b0;

  byte_ring_fifo_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample results mid-cycle, well away from the edge that moves them
  always @(negedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_data);
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               stall_cycles, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    if (calm) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic brf_in_t make_item(logic [2:0] op, logic [63:0] data, logic [3:0] len,
                                        logic [6:0] cnt, logic [15:0] pos);
    brf_in_t it;
    it.opcode      = op;
    it.chunk_bytes = data;
    it.chunk_len   = len;
    it.count       = cnt;
    it.position    = pos;
    return it;
  endfunction

  // Mostly legal lengths and short counts, with a tail of oversized fields
  function automatic brf_in_t random_item();
    brf_in_t     it;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    it.chunk_bytes = {$urandom(), $urandom()};
    it.chunk_len   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
    case ($urandom_range(0, 9))
      0:       it.count = 7'($urandom_range(65, 127));
      1, 2:    it.count = 7'($urandom_range(0, 64));
      default: it.count = 7'($urandom_range(0, 8));
    endcase
    it.position = 16'($urandom_range(0, 65535));
    if (pick < 25)      it.opcode = OP_WRITE;
    else if (pick < 45) it.opcode = OP_TRY_WRITE;
    else if (pick < 65) it.opcode = OP_READ;
    else if (pick < 73) it.opcode = OP_REMOVE;
    else if (pick < 83) it.opcode = OP_PEEK;
    else if (pick < 95) it.opcode = OP_GET;
    else                it.opcode = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    if (it.opcode == OP_GET) it.position = sb.fix_position(it.position);
    return it;
  endfunction

  // Hold start until the block takes the item, then note it
  task automatic send_item(input brf_in_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // Wait for every expected result, then let the block settle
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  initial begin
    logic [6:0] cap_val;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring replies and unused opcodes at reset capacity
    send_item(make_item(OP_PEEK, 64'd0, 4'd0, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_READ, 64'd0, 4'd0, 7'd5, 16'd0), pick_gap());
    send_item(make_item(OP_REMOVE, 64'd0, 4'd0, 7'd64, 16'd0), pick_gap());
    send_item(make_item(OP_GET, 64'd0, 4'd0, 7'd0, 16'hFFFF), pick_gap());
    send_item(make_item(OP_UNUSED_6, 64'd0, 4'd0, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_UNUSED_7, '1, '1, '1, '1), pick_gap());

    // Fill: full chunk, oversized length, empty chunk, try-write, get
    send_item(make_item(OP_WRITE, '1, 4'd8, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_WRITE, 64'h0123_4567_89AB_CDEF, 4'd15, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_WRITE, 64'd0, 4'd0, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_TRY_WRITE, 64'hA55A_C33C_0FF0_9669, 4'd8, 7'd0, 16'd0),
              pick_gap());
    send_item(make_item(OP_GET, 64'd0, 4'd0, 7'd0, sb.fix_position(16'hFFFF)), pick_gap());

    // Drain: zero count, short read, pop, drop, oversized count
    send_item(make_item(OP_READ, 64'd0, 4'd0, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_READ, 64'd0, 4'd0, 7'd3, 16'd0), pick_gap());
    send_item(make_item(OP_PEEK, 64'd0, 4'd0, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_REMOVE, 64'd0, 4'd0, 7'd2, 16'd0), pick_gap());
    send_item(make_item(OP_READ, 64'd0, 4'd0, 7'd127, 16'd0), pick_gap());

    // Zero capacity is taken as one slot
    drain_results();
    write_capacity(7'd0);
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_BEEF, 4'd2, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_TRY_WRITE, 64'h0000_0000_0000_1E7A, 4'd2, 7'd0, 16'd0),
              pick_gap());
    send_item(make_item(OP_GET, 64'd0, 4'd0, 7'd0, sb.fix_position(16'hFFFF)), pick_gap());
    send_item(make_item(OP_PEEK, 64'd0, 4'd0, 7'd0, 16'd0), pick_gap());

    // Small ring run to full, then read it out with a count of 64
    drain_results();
    write_capacity(7'd9);
    send_item(make_item(OP_WRITE, 64'hFEDC_BA98_7654_3210, 4'd8, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_5A5A, 4'd2, 7'd0, 16'd0), pick_gap());
    send_item(make_item(OP_TRY_WRITE, 64'h0000_0000_0077_6655, 4'd3, 7'd0, 16'd0),
              pick_gap());
    send_item(make_item(OP_READ, 64'd0, 4'd0, 7'd64, 16'd0), pick_gap());

    // Random phases, each under its own capacity
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) cap_val = 7'd127;
      else if (ph == 1) cap_val = 7'd2;
      else if (ph == 2) cap_val = 7'd64;
      else begin
        case ($urandom_range(0, 5))
          0:       cap_val = 7'd0;
          1:       cap_val = 7'd1;
          2:       cap_val = 7'($urandom_range(65, 127));
          3:       cap_val = 7'd64;
          default: cap_val = 7'($urandom_range(2, 63));
        endcase
      end
      calm = ($urandom_range(0, 3) == 0);
      drain_results();
      write_capacity(cap_val);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), pick_gap());
    end

    drain_results();
    $display("Run covered %0d items and %0d results across %0d capacity settings.",
             items_sent, sb.results_seen, cap_writes);
    $display("Settings spanned one slot, full depth and out-of-range writes; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
